FILE: design/acbc_pkg.sv
// Package: constants, types and AES helper functions for the CBC decryptor.
`timescale 1ns / 1ps
package acbc_pkg;

  localparam int unsigned NumRounds  = 10;
  localparam int unsigned KeyWords   = 44;
  localparam int unsigned BlockBytes = 16;
  localparam int unsigned CfgIdxW    = 3;
  localparam int unsigned CfgDataW   = 64;
  localparam int unsigned RkAddrW    = 6;
  localparam int unsigned RoundW     = 4;

  localparam logic [CfgIdxW-1:0] RegKeyHigh   = 3'd0;
  localparam logic [CfgIdxW-1:0] RegKeyLow    = 3'd1;
  localparam logic [CfgIdxW-1:0] RegIvHigh    = 3'd2;
  localparam logic [CfgIdxW-1:0] RegIvLow     = 3'd3;
  localparam logic [CfgIdxW-1:0] RegChainMode = 3'd4;

  typedef struct packed {
    logic [63:0] cipher_high;
    logic [63:0] cipher_low;
    logic        first_block;
    logic        last_block;
  } in_beat_t;

  typedef struct packed {
    logic [63:0] plain_high;
    logic [63:0] plain_low;
    logic [4:0]  plain_length;
  } out_beat_t;

  typedef enum logic [1:0] {
    KsIdle,
    KsRun
  } ks_state_e;

  typedef enum logic [2:0] {
    CoIdle,
    CoKeyFirst,
    CoRound,
    CoLast,
    CoDone
  } core_state_e;

  // Forward S-box.
  function automatic logic [7:0] sbox(input logic [7:0] x);
    logic [7:0] t [256];
    t = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
    return t[x];
  endfunction

  // Inverse S-box.
  function automatic logic [7:0] inv_sbox(input logic [7:0] x);
    logic [7:0] t [256];
    t = '{
      8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
      8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
      8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
      8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
      8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
      8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
      8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
      8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
      8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
      8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
      8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
      8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
      8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
      8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
      8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
      8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d};
    return t[x];
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] x);
    return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
  endfunction

  // Inverse MixColumns on one 32-bit column, byte 0 in bits 31:24.
  function automatic logic [31:0] inv_mix_col(input logic [31:0] c);
    logic [7:0] a [4];
    logic [7:0] x2 [4];
    logic [7:0] x4 [4];
    logic [7:0] x8 [4];
    logic [7:0] m9 [4];
    logic [7:0] mb [4];
    logic [7:0] md [4];
    logic [7:0] me [4];
    logic [31:0] r;
    for (int i = 0; i < 4; i++) begin
      a[i]  = c[31-8*i -: 8];
      x2[i] = xtime(a[i]);
      x4[i] = xtime(x2[i]);
      x8[i] = xtime(x4[i]);
      m9[i] = x8[i] ^ a[i];
      mb[i] = x8[i] ^ x2[i] ^ a[i];
      md[i] = x8[i] ^ x4[i] ^ a[i];
      me[i] = x8[i] ^ x4[i] ^ x2[i];
    end
    r[31:24] = me[0] ^ mb[1] ^ md[2] ^ m9[3];
    r[23:16] = m9[0] ^ me[1] ^ mb[2] ^ md[3];
    r[15:8]  = md[0] ^ m9[1] ^ me[2] ^ mb[3];
    r[7:0]   = mb[0] ^ md[1] ^ m9[2] ^ me[3];
    return r;
  endfunction

endpackage

FILE: design/acbc_stream_if.sv
// Valid/ready channel interface with a generic payload type.
`timescale 1ns / 1ps
interface acbc_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

FILE: design/acbc_ram.sv
// Generic single-port write, single-port read RAM with registered read.
`timescale 1ns / 1ps
module acbc_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 44
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

FILE: design/acbc_key_exp.sv
// Key schedule sequencer: one round-key word per cycle into the key RAM.
`timescale 1ns / 1ps
module acbc_key_exp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [127:0]                  key_i,
  output logic                          busy_o,
  output logic                          we_o,
  output logic [acbc_pkg::RkAddrW-1:0]  waddr_o,
  output logic [31:0]                   wdata_o
);
  import acbc_pkg::*;

  ks_state_e             state_q, state_d;
  logic [RkAddrW-1:0]    idx_q, idx_d;
  logic [7:0]            rcon_q, rcon_d;
  logic [31:0]           win_q [4];
  logic [31:0]           t_rot;
  logic [31:0]           t_w;

  // Next word from the last four.
  always_comb begin
    t_rot = {win_q[3][23:0], win_q[3][31:24]};
    if (idx_q[1:0] == 2'd0) begin
      t_w = {sbox(t_rot[31:24]), sbox(t_rot[23:16]), sbox(t_rot[15:8]), sbox(t_rot[7:0])}
            ^ {rcon_q, 24'h0};
    end else begin
      t_w = win_q[3];
    end
  end

  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    rcon_d  = rcon_q;
    we_o    = 1'b0;
    waddr_o = idx_q;
    wdata_o = win_q[0] ^ t_w;
    case (state_q)
      KsIdle: begin
        if (start_i) begin
          state_d = KsRun;
          idx_d   = '0;
          rcon_d  = 8'h01;
        end
      end
      KsRun: begin
        we_o = 1'b1;
        if (idx_q < RkAddrW'(4)) begin
          wdata_o = key_i[127-32*idx_q[1:0] -: 32];
        end
        if (idx_q >= RkAddrW'(4) && idx_q[1:0] == 2'd0) begin
          rcon_d = xtime(rcon_q);
        end
        if (idx_q == RkAddrW'(KeyWords - 1)) begin
          state_d = KsIdle;
        end
        idx_d = idx_q + RkAddrW'(1);
      end
      default: state_d = KsIdle;
    endcase
    if (start_i) begin
      state_d = KsRun;
      idx_d   = '0;
      rcon_d  = 8'h01;
    end
  end

  assign busy_o = (state_q == KsRun) || start_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= KsRun;
      idx_q   <= '0;
      rcon_q  <= 8'h01;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      rcon_q  <= rcon_d;
    end
  end

  // Sliding window of the last four words.
  always_ff @(posedge clk_i) begin
    if (we_o) begin
      win_q[0] <= win_q[1];
      win_q[1] <= win_q[2];
      win_q[2] <= win_q[3];
      win_q[3] <= wdata_o;
    end
  end
endmodule

FILE: design/acbc_core.sv
// Round sequencer: inverse AES rounds in turn on a shared round unit.
`timescale 1ns / 1ps
module acbc_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [127:0]                  block_i,
  input  logic [31:0]                   rk_i,
  output logic [acbc_pkg::RkAddrW-1:0]  rk_raddr_o,
  output logic                          done_o,
  output logic [127:0]                  state_o
);
  import acbc_pkg::*;

  core_state_e        st_q, st_d;
  logic [RoundW-1:0]  rnd_q, rnd_d;
  logic [1:0]         col_q, col_d;
  logic [127:0]       s_q, s_d;
  logic [127:0]       rk_q;
  logic [127:0]       ss;
  logic [127:0]       ak;
  logic [127:0]       mx;

  // Inverse shift rows and substitution; byte r+4c at bits 127-8*(r+4c).
  always_comb begin
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        ss[127-8*(r+4*c) -: 8] = inv_sbox(s_q[127-8*(r+4*((c-r)&3)) -: 8]);
      end
    end
    ak = ss ^ rk_q;
    for (int c = 0; c < 4; c++) begin
      mx[127-32*c -: 32] = inv_mix_col(ak[127-32*c -: 32]);
    end
  end

  // Round key words arrive one per cycle; a full round key sits in rk_q at
  // column one of the following fetch round, which is when it is applied.
  always_comb begin
    st_d  = st_q;
    rnd_d = rnd_q;
    col_d = col_q + 2'd1;
    s_d   = s_q;
    done_o = 1'b0;
    rk_raddr_o = RkAddrW'({rnd_q, col_q});
    case (st_q)
      CoIdle: begin
        col_d = '0;
        if (start_i) begin
          st_d  = CoKeyFirst;
          rnd_d = RoundW'(NumRounds);
          s_d   = block_i;
        end
      end
      CoKeyFirst: begin
        if (col_q == 2'd1 && rnd_q != RoundW'(NumRounds)) begin
          s_d = s_q ^ rk_q;
          st_d = CoRound;
        end
        if (col_q == 2'd3) begin
          rnd_d = rnd_q - RoundW'(1);
        end
      end
      CoRound: begin
        if (col_q == 2'd1) begin
          s_d = mx;
          if (rnd_q == RoundW'(0)) begin
            st_d = CoLast;
          end
        end
        if (col_q == 2'd3 && rnd_q != RoundW'(0)) begin
          rnd_d = rnd_q - RoundW'(1);
        end
      end
      // Final round: no mix, key zero.
      CoLast: begin
        if (col_q == 2'd1) begin
          s_d = ak;
          st_d = CoDone;
        end
      end
      CoDone: begin
        done_o = 1'b1;
        st_d   = CoIdle;
      end
      default: st_d = CoIdle;
    endcase
  end

  assign state_o = s_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= CoIdle;
      rnd_q <= '0;
      col_q <= '0;
    end else begin
      st_q  <= st_d;
      rnd_q <= rnd_d;
      col_q <= col_d;
    end
  end

  // Shift in key words; the RAM read data arrives in the cycle after its address.
  always_ff @(posedge clk_i) begin
    s_q  <= s_d;
    rk_q <= {rk_q[95:0], rk_i};
  end
endmodule

FILE: design/aes128_cbc_decrypt_pkcs7.sv
// Top level: AES-128 CBC decryptor with PKCS#7 padding check.
//
//  channel   dir  handshake          payload
//  in_if     in   valid/ready        cipher_high, cipher_low, first_block, last_block
//  out_if    out  valid/ready        plain_high, plain_low, plain_length
//  cfg       in   cfg_we_i only      cfg_idx_i, cfg_data_i
//
// The key RAM gives one 32-bit round-key word per cycle, so each of the
// eleven key additions waits four reads behind the registered read, and a
// done state follows the last one.
// After reset, and after each key write, the schedule is rebuilt with the
// input held off. Output is held in a register until taken; the next
// beat is accepted only when the result register is empty, so a new block
// is not taken before the last result has been taken.
`timescale 1ns / 1ps
module aes128_cbc_decrypt_pkcs7 (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [acbc_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [acbc_pkg::CfgDataW-1:0] cfg_data_i,
  acbc_stream_if.sink                   in_if,
  acbc_stream_if.source                 out_if
);
  import acbc_pkg::*;

  logic [63:0]  key_high_q, key_low_q, iv_high_q, iv_low_q;
  logic         chain_mode_q;
  logic [127:0] chain_q;
  logic [127:0] cipher_q;
  logic         first_q, last_q;
  logic         busy_q;
  logic         ks_start, ks_busy, ks_we;
  logic [RkAddrW-1:0] ks_waddr, rk_raddr;
  logic [31:0]  ks_wdata, rk_rdata;
  logic         core_done;
  logic [127:0] core_state;
  logic [127:0] chain_use;
  logic [127:0] plain;
  logic [7:0]   pn;
  logic         pad_ok;
  logic [4:0]   len;
  logic         out_valid_q;
  out_beat_t    out_q;
  logic         accept;

  assign ks_start = cfg_we_i && (cfg_idx_i == RegKeyHigh || cfg_idx_i == RegKeyLow);

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_high_q   <= '0;
      key_low_q    <= '0;
      iv_high_q    <= '0;
      iv_low_q     <= '0;
      chain_mode_q <= 1'b1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegKeyHigh:   key_high_q   <= cfg_data_i;
        RegKeyLow:    key_low_q    <= cfg_data_i;
        RegIvHigh:    iv_high_q    <= cfg_data_i;
        RegIvLow:     iv_low_q     <= cfg_data_i;
        RegChainMode: chain_mode_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // A key written this cycle is captured with the live value in key_run_q;
  // the expander reads its key words from that register while it runs.
  logic [127:0] key_live;
  always_comb begin
    key_live = {key_high_q, key_low_q};
    if (cfg_we_i && cfg_idx_i == RegKeyHigh) key_live[127:64] = cfg_data_i;
    if (cfg_we_i && cfg_idx_i == RegKeyLow)  key_live[63:0]   = cfg_data_i;
  end
  logic [127:0] key_run_q;
  always_ff @(posedge clk_i) begin
    if (ks_start) key_run_q <= key_live;
  end
  logic ks_first_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) ks_first_q <= 1'b1;
    else if (ks_start) ks_first_q <= 1'b0;
  end

  acbc_key_exp u_key_exp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (ks_start),
    .key_i   (ks_first_q ? 128'h0 : key_run_q),
    .busy_o  (ks_busy),
    .we_o    (ks_we),
    .waddr_o (ks_waddr),
    .wdata_o (ks_wdata)
  );

  acbc_ram #(.Width(32), .Depth(KeyWords)) u_rk_ram (
    .clk_i   (clk_i),
    .we_i    (ks_we),
    .waddr_i (ks_waddr),
    .wdata_i (ks_wdata),
    .raddr_i (rk_raddr),
    .rdata_o (rk_rdata)
  );

  assign in_if.ready = !busy_q && !out_valid_q && !ks_busy;
  assign accept      = in_if.valid && in_if.ready;

  // Capture the beat and track the block in flight.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else if (accept) begin
      busy_q <= 1'b1;
    end else if (core_done) begin
      busy_q <= 1'b0;
    end
  end
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cipher_q <= {in_if.payload.cipher_high, in_if.payload.cipher_low};
      first_q  <= in_if.payload.first_block;
      last_q   <= in_if.payload.last_block;
    end
  end

  acbc_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (accept),
    .block_i    ({in_if.payload.cipher_high, in_if.payload.cipher_low}),
    .rk_i       (rk_rdata),
    .rk_raddr_o (rk_raddr),
    .done_o     (core_done),
    .state_o    (core_state)
  );

  // Chain, then check padding.
  always_comb begin
    chain_use = first_q ? {iv_high_q, iv_low_q} : chain_q;
    plain     = chain_mode_q ? (core_state ^ chain_use) : core_state;
    pn        = plain[7:0];
    pad_ok    = (pn >= 8'd1) && (pn <= 8'd16);
    for (int i = 0; i < BlockBytes; i++) begin
      if ((8'(BlockBytes - i) <= pn) && (plain[127-8*i -: 8] != pn)) begin
        pad_ok = 1'b0;
      end
    end
    len = 5'd16;
    if (chain_mode_q && last_q && pad_ok) begin
      len = 5'(8'd16 - pn);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chain_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (core_done) begin
        out_valid_q <= 1'b1;
        if (chain_mode_q) chain_q <= cipher_q;
      end else if (out_if.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk_i) begin
    if (core_done) begin
      out_q.plain_high   <= plain[127:64];
      out_q.plain_low    <= plain[63:0];
      out_q.plain_length <= len;
    end
  end

  assign out_if.valid   = out_valid_q;
  assign out_if.payload = out_q;
endmodule

FILE: sim/aes128_cbc_decrypt_pkcs7_tb.sv
// Self-checking testbench for the AES-128 CBC decryptor with PKCS#7 length check.
`timescale 1ns / 1ps
module aes128_cbc_decrypt_pkcs7_tb;
  import acbc_pkg::*;

  localparam int unsigned CycleLimit = 1500000;
  localparam int unsigned DrainWait  = 100;
  localparam int unsigned LongHold   = 400;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;

  acbc_stream_if #(.payload_t(in_beat_t))  in_ch ();
  acbc_stream_if #(.payload_t(out_beat_t)) out_ch ();

  aes128_cbc_decrypt_pkcs7 dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_if      (in_ch),
    .out_if     (out_ch)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Shadow of the block: tables, key schedule, registers, chaining value
  logic [7:0]  fsb [256];
  logic [7:0]  isb [256];
  logic [31:0] sched [44];
  logic [63:0] key_hi_q, key_lo_q, iv_hi_q, iv_lo_q, chain_hi, chain_lo;
  logic        cbc_on;

  out_beat_t   plain_fifo [$];
  int unsigned mismatches = 0;
  int unsigned cycles = 0;
  bit          hold_go = 1'b0;

  function automatic logic [7:0] rotl8(logic [7:0] x, int s);
    logic [7:0] r;
    r = (x << s) | (x >> (8 - s));
    return r;
  endfunction

  function automatic logic [7:0] gf_dbl(logic [7:0] x);
    return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] gf_mul(logic [7:0] a, logic [7:0] b);
    logic [7:0] r;
    r = '0;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) r = r ^ a;
      a = gf_dbl(a);
    end
    return r;
  endfunction

  // Build both S-boxes from the field generator
  task automatic build_tables();
    logic [7:0] p, q, x;
    p = 8'h01;
    q = 8'h01;
    do begin
      p = p ^ (p << 1) ^ (p[7] ? 8'h1b : 8'h00);
      q = q ^ (q << 1);
      q = q ^ (q << 2);
      q = q ^ (q << 4);
      if (q[7]) q = q ^ 8'h09;
      x = q ^ rotl8(q, 1) ^ rotl8(q, 2) ^ rotl8(q, 3) ^ rotl8(q, 4);
      fsb[p] = x ^ 8'h63;
    end while (p != 8'h01);
    fsb[0] = 8'h63;
    for (int i = 0; i < 256; i++) isb[fsb[i]] = i[7:0];
  endtask

  task automatic expand_schedule();
    logic [31:0] t;
    logic [7:0]  rc;
    rc = 8'h01;
    sched[0] = key_hi_q[63:32];
    sched[1] = key_hi_q[31:0];
    sched[2] = key_lo_q[63:32];
    sched[3] = key_lo_q[31:0];
    for (int i = 4; i < 44; i++) begin
      t = sched[i-1];
      if (i % 4 == 0) begin
        t = {t[23:0], t[31:24]};
        t = {fsb[t[31:24]] ^ rc, fsb[t[23:16]], fsb[t[15:8]], fsb[t[7:0]]};
        rc = gf_dbl(rc);
      end
      sched[i] = sched[i-4] ^ t;
    end
  endtask

  // Plain inverse cipher on one 128-bit block, byte 0 in the top bits
  function automatic logic [127:0] inv_cipher(logic [127:0] blk);
    logic [7:0]  s [16];
    logic [7:0]  t [16];
    logic [7:0]  a0, a1, a2, a3;
    logic [127:0] r;
    for (int i = 0; i < 16; i++) s[i] = blk[127-8*i -: 8];
    for (int rnd = 10; rnd >= 0; rnd--) begin
      if (rnd < 10) begin
        for (int row = 0; row < 4; row++)
          for (int c = 0; c < 4; c++)
            t[row+4*c] = isb[s[row+4*((c-row+4)%4)]];
        s = t;
      end
      for (int c = 0; c < 4; c++)
        for (int j = 0; j < 4; j++)
          s[4*c+j] = s[4*c+j] ^ sched[rnd*4+c][31-8*j -: 8];
      if (rnd > 0 && rnd < 10) begin
        for (int c = 0; c < 4; c++) begin
          a0 = s[4*c]; a1 = s[4*c+1]; a2 = s[4*c+2]; a3 = s[4*c+3];
          s[4*c]   = gf_mul(a0, 8'd14) ^ gf_mul(a1, 8'd11) ^ gf_mul(a2, 8'd13) ^
                     gf_mul(a3, 8'd9);
          s[4*c+1] = gf_mul(a0, 8'd9) ^ gf_mul(a1, 8'd14) ^ gf_mul(a2, 8'd11) ^
                     gf_mul(a3, 8'd13);
          s[4*c+2] = gf_mul(a0, 8'd13) ^ gf_mul(a1, 8'd9) ^ gf_mul(a2, 8'd14) ^
                     gf_mul(a3, 8'd11);
          s[4*c+3] = gf_mul(a0, 8'd11) ^ gf_mul(a1, 8'd13) ^ gf_mul(a2, 8'd9) ^
                     gf_mul(a3, 8'd14);
        end
      end
    end
    for (int i = 0; i < 16; i++) r[127-8*i -: 8] = s[i];
    return r;
  endfunction

  // Decrypt one beat, chain it and work out the valid byte count
  function automatic out_beat_t decrypt_beat(in_beat_t b);
    out_beat_t    o;
    logic [127:0] pt;
    logic [7:0]   pn;
    bit           ok;
    pt = inv_cipher({b.cipher_high, b.cipher_low});
    o.plain_length = 5'd16;
    if (cbc_on) begin
      if (b.first_block) begin
        chain_hi = iv_hi_q;
        chain_lo = iv_lo_q;
      end
      pt = pt ^ {chain_hi, chain_lo};
      chain_hi = b.cipher_high;
      chain_lo = b.cipher_low;
      if (b.last_block) begin
        pn = pt[7:0];
        if (pn >= 1 && pn <= 16) begin
          ok = 1'b1;
          for (int i = 16 - pn; i < 16; i++)
            if (pt[127-8*i -: 8] != pn) ok = 1'b0;
          if (ok) o.plain_length = 5'(16 - pn);
        end
      end
    end
    o.plain_high = pt[127:64];
    o.plain_low  = pt[63:0];
    return o;
  endfunction

  task automatic set_reg(logic [CfgIdxW-1:0] idx, logic [63:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      RegKeyHigh: begin key_hi_q = val; expand_schedule(); end
      RegKeyLow: begin key_lo_q = val; expand_schedule(); end
      RegIvHigh: iv_hi_q = val;
      RegIvLow: iv_lo_q = val;
      RegChainMode: cbc_on = val[0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  // Wait for every plaintext beat, then let the core settle
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (plain_fifo.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
  endtask

  // Offer one beat in bursts; record its plaintext when taken
  int unsigned burst_left = 0;
  task automatic send_beat(in_beat_t b, bit typed, out_beat_t want);
    out_beat_t got;
    in_ch.valid   <= 1'b1;
    in_ch.payload <= b;
    do @(posedge clk_i); while (!in_ch.ready);
    got = decrypt_beat(b);
    plain_fifo.push_back(typed ? want : got);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      if ($urandom_range(0, 2) != 0) begin
        in_ch.valid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk_i);
      end
    end else begin
      burst_left--;
    end
  endtask

  // Make a plaintext with the given pad byte; optionally break the first pad byte
  function automatic logic [127:0] padded_text(int pn, bit corrupt);
    logic [127:0] p;
    p = {$urandom, $urandom, $urandom, $urandom};
    if (pn >= 1 && pn <= 16) begin
      for (int i = 16 - pn; i < 16; i++) p[127-8*i -: 8] = pn[7:0];
      if (corrupt && pn >= 2)
        p[127-8*(16-pn) -: 8] = pn[7:0] ^ 8'($urandom_range(1, 255));
    end else begin
      p[7:0] = pn[7:0];
    end
    return p;
  endfunction

  // One message: the second-to-last block is chosen so the last one unpads as asked
  task automatic send_message(int n, bit framed, int pn, bit corrupt);
    logic [127:0] blk [6];
    in_beat_t     b;
    out_beat_t    none;
    none = '0;
    for (int i = 0; i < n; i++) blk[i] = {$urandom, $urandom, $urandom, $urandom};
    if (framed && n >= 2)
      blk[n-2] = inv_cipher(blk[n-1]) ^ padded_text(pn, corrupt);
    for (int i = 0; i < n; i++) begin
      b.cipher_high = blk[i][127:64];
      b.cipher_low  = blk[i][63:0];
      b.first_block = framed ? (i == 0) : 1'($urandom_range(0, 1));
      b.last_block  = framed ? (i == n - 1) : 1'($urandom_range(0, 1));
      send_beat(b, 1'b0, none);
    end
  endtask

  typedef struct {
    bit                 is_write;
    logic [CfgIdxW-1:0] idx;
    logic [63:0]        hi;
    logic [63:0]        lo;
    bit                 first;
    bit                 last;
    bit                 typed;
    logic [63:0]        exp_hi;
    logic [63:0]        exp_lo;
    logic [4:0]         exp_len;
  } step_t;

  localparam logic [63:0] Ones = 64'hffff_ffff_ffff_ffff;

  // Directed steps: reset state, FIPS-197 known answer in both modes, extremes
  step_t directed [12] = '{
    '{0, RegKeyHigh, 64'h0, 64'h0, 0, 0, 0, 64'h0, 64'h0, 5'd0},
    '{0, RegKeyHigh, Ones, Ones, 0, 1, 0, 64'h0, 64'h0, 5'd0},
    '{1, RegKeyHigh, 64'h0001020304050607, 64'h0, 0, 0, 0, 64'h0, 64'h0, 5'd0},
    '{1, RegKeyLow, 64'h08090a0b0c0d0e0f, 64'h0, 0, 0, 0, 64'h0, 64'h0, 5'd0},
    '{1, RegChainMode, 64'h0, 64'h0, 0, 0, 0, 64'h0, 64'h0, 5'd0},
    '{0, RegKeyHigh, 64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a, 1, 1, 1,
      64'h0011223344556677, 64'h8899aabbccddeeff, 5'd16},
    '{1, RegChainMode, 64'h1, 64'h0, 0, 0, 0, 64'h0, 64'h0, 5'd0},
    '{0, RegKeyHigh, 64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a, 1, 0, 1,
      64'h0011223344556677, 64'h8899aabbccddeeff, 5'd16},
    '{1, RegIvHigh, Ones, 64'h0, 0, 0, 0, 64'h0, 64'h0, 5'd0},
    '{1, RegIvLow, Ones, 64'h0, 0, 0, 0, 64'h0, 64'h0, 5'd0},
    '{0, RegKeyHigh, 64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a, 1, 1, 1,
      64'hffeeddccbbaa9988, 64'h7766554433221100, 5'd16},
    '{0, RegKeyHigh, Ones, 64'h0, 0, 1, 0, 64'h0, 64'h0, 5'd0}
  };

  // Receiver: changing stall patterns plus one long hold-off
  int unsigned hold_left = 0;
  bit          hold_done = 1'b0;
  initial out_ch.ready = 1'b0;
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (hold_go && !hold_done) begin
      hold_done <= 1'b1;
      hold_left <= LongHold;
      out_ch.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ch.ready <= 1'b0;
    end else begin
      case ((cycles / 97) % 4)
        0: out_ch.ready <= 1'b1;
        1: out_ch.ready <= $urandom_range(0, 1);
        2: out_ch.ready <= (cycles % 5 == 0);
        default: out_ch.ready <= ($urandom_range(0, 9) != 0);
      endcase
    end
  end

  // Compare every plaintext beat against the oldest expectation
  always @(posedge clk_i) begin
    out_beat_t want;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (plain_fifo.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected plaintext beat %h", out_ch.payload);
      end else begin
        want = plain_fifo.pop_front();
        if (out_ch.payload.plain_high !== want.plain_high ||
            out_ch.payload.plain_low !== want.plain_low ||
            out_ch.payload.plain_length !== want.plain_length) begin
          mismatches++;
          if (mismatches <= 10)
            $display("plaintext mismatch: expected %h %h len %0d, got %h %h len %0d",
                     want.plain_high, want.plain_low, want.plain_length,
                     out_ch.payload.plain_high, out_ch.payload.plain_low,
                     out_ch.payload.plain_length);
        end
      end
    end
    if (cycles > CycleLimit) begin
      $display("aes128_cbc_decrypt_pkcs7_tb: errors");
      $finish;
    end
  end

  initial begin
    in_beat_t  b;
    out_beat_t w;
    int        pads [6];
    int        pn;
    pads = '{1, 16, 0, 17, 7, 9};
    in_ch.valid   = 1'b0;
    in_ch.payload = '0;
    build_tables();
    key_hi_q = '0; key_lo_q = '0; iv_hi_q = '0; iv_lo_q = '0;
    chain_hi = '0; chain_lo = '0;
    cbc_on = 1'b1;
    expand_schedule();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Walk the directed steps
    foreach (directed[i]) begin
      if (directed[i].is_write) begin
        drain();
        set_reg(directed[i].idx, directed[i].hi);
      end else begin
        b = '{directed[i].hi, directed[i].lo, directed[i].first, directed[i].last};
        w = '{directed[i].exp_hi, directed[i].exp_lo, directed[i].exp_len};
        send_beat(b, directed[i].typed, w);
      end
    end
    // Pad lengths: full, single, zero byte, too large, broken inner byte
    foreach (pads[i]) send_message(2, 1'b1, pads[i], i >= 4);

    // Random phases over several key, IV and mode settings
    for (int ph = 0; ph < 6; ph++) begin
      drain();
      case (ph)
        0: begin set_reg(RegKeyHigh, '0); set_reg(RegKeyLow, '0); end
        1: begin set_reg(RegKeyHigh, Ones); set_reg(RegKeyLow, Ones); end
        default: begin
          set_reg(RegKeyHigh, {$urandom, $urandom});
          set_reg(RegKeyLow, {$urandom, $urandom});
        end
      endcase
      set_reg(RegIvHigh, ph == 1 ? Ones : {$urandom, $urandom});
      set_reg(RegIvLow, ph == 0 ? 64'h0 : {$urandom, $urandom});
      set_reg(RegChainMode, 64'(ph != 3));
      if (ph == 2) hold_go = 1'b1;
      for (int cnt = 0; cnt < 155; ) begin
        int n;
        n = $urandom_range(1, 5);
        pn = ($urandom_range(0, 9) == 0) ? 17 * $urandom_range(0, 1) : $urandom_range(1, 16);
        send_message(n, $urandom_range(0, 4) != 0, pn, $urandom_range(0, 6) == 0);
        cnt += n;
      end
    end

    drain();
    if (mismatches == 0) begin
      $display("aes128_cbc_decrypt_pkcs7_tb: clean");
    end else begin
      $display("aes128_cbc_decrypt_pkcs7_tb: errors");
    end
    $finish;
  end

endmodule

FILE: files.f
design/acbc_pkg.sv
design/acbc_stream_if.sv
design/acbc_ram.sv
design/acbc_key_exp.sv
design/acbc_core.sv
design/aes128_cbc_decrypt_pkcs7.sv
sim/aes128_cbc_decrypt_pkcs7_tb.sv
